/* rtl/sql_statement_lexer_core_defines.svh */
// Assertion macros used by the lexer core.
`ifndef SQL_STATEMENT_LEXER_CORE_DEFINES_SVH
`define SQL_STATEMENT_LEXER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SLC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SLC_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define SLC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* rtl/sqllex_pkg.sv */
package sqllex_pkg;

  localparam int unsigned MAX_TEXT_BYTES = 4096;
  localparam int unsigned CNT_W = $clog2(MAX_TEXT_BYTES + 1);
  localparam int unsigned OFF_W = 13;

  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_QUOTE      = 8'h27;
  localparam logic [7:0] CH_LPAREN     = 8'h28;
  localparam logic [7:0] CH_RPAREN     = 8'h29;
  localparam logic [7:0] CH_COMMA      = 8'h2C;
  localparam logic [7:0] CH_SEMI       = 8'h3B;

  // Fault codes E1100 and E1101.
  localparam logic FAULT_UNEXPECTED = 1'b0;
  localparam logic FAULT_UNTERM     = 1'b1;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_IDENT,
    MODE_NUMBER,
    MODE_STRING,
    MODE_QUOTE,
    MODE_ERROR
  } mode_t;

  typedef enum logic [1:0] {
    EV_CONTENT  = 2'd0,
    EV_COMPLETE = 2'd1,
    EV_ERROR    = 2'd2
  } event_t;

  typedef enum logic [2:0] {
    TK_IDENT  = 3'd0,
    TK_NUMBER = 3'd1,
    TK_STRING = 3'd2,
    TK_LPAREN = 3'd3,
    TK_RPAREN = 3'd4,
    TK_COMMA  = 3'd5,
    TK_SEMI   = 3'd6,
    TK_END    = 3'd7
  } token_t;

  typedef struct packed {
    event_t           event_type;
    token_t           token_type;
    logic [OFF_W-1:0] offset;
    logic [7:0]       payload_byte;
    logic             fault_code;
    logic             final_in_run;
  } result_t;

  // What one lexing step hands to the output buffer.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    first;
    result_t    second;
  } lex_out_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0D) || c == 8'h20;
  endfunction

endpackage

/* rtl/sqllex_engine.sv */
module sqllex_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic [7:0]          char_in,
  input  logic                end_of_text,
  output sqllex_pkg::lex_out_t lex
);
  import sqllex_pkg::*;

  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic [CNT_W-1:0] token_start_r, token_start_nxt;

  result_t          bb_res;
  logic             bb_emit;
  logic             bb_start;
  mode_t            bb_mode;
  logic [OFF_W-1:0] pos_off;
  logic [OFF_W-1:0] start_off;
  result_t          r0, r1;
  logic [1:0]       cnt;

  assign pos_off   = OFF_W'(byte_count_r);
  assign start_off = OFF_W'(token_start_r);

  // What a byte does when no token is open.
  always_comb begin
    bb_res   = '0;
    bb_emit  = 1'b0;
    bb_start = 1'b0;
    bb_mode  = MODE_IDLE;
    bb_res.offset = pos_off;
    if (is_space(char_in)) begin
      bb_mode = MODE_IDLE;
    end else if (is_alpha(char_in) || char_in == CH_UNDERSCORE) begin
      bb_mode  = MODE_IDENT;
      bb_start = 1'b1;
      bb_emit  = 1'b1;
      bb_res.event_type   = EV_CONTENT;
      bb_res.token_type   = TK_IDENT;
      bb_res.payload_byte = char_in;
    end else if (is_digit(char_in)) begin
      bb_mode  = MODE_NUMBER;
      bb_start = 1'b1;
      bb_emit  = 1'b1;
      bb_res.event_type   = EV_CONTENT;
      bb_res.token_type   = TK_NUMBER;
      bb_res.payload_byte = char_in;
    end else begin
      unique case (char_in)
        CH_QUOTE: begin
          bb_mode  = MODE_STRING;
          bb_start = 1'b1;
        end
        CH_LPAREN: begin
          bb_emit = 1'b1;
          bb_res.event_type = EV_COMPLETE;
          bb_res.token_type = TK_LPAREN;
        end
        CH_RPAREN: begin
          bb_emit = 1'b1;
          bb_res.event_type = EV_COMPLETE;
          bb_res.token_type = TK_RPAREN;
        end
        CH_COMMA: begin
          bb_emit = 1'b1;
          bb_res.event_type = EV_COMPLETE;
          bb_res.token_type = TK_COMMA;
        end
        CH_SEMI: begin
          bb_emit = 1'b1;
          bb_res.event_type = EV_COMPLETE;
          bb_res.token_type = TK_SEMI;
        end
        default: begin
          bb_mode = MODE_ERROR;
          bb_emit = 1'b1;
          bb_res.event_type = EV_ERROR;
          bb_res.fault_code = FAULT_UNEXPECTED;
        end
      endcase
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    token_start_nxt = token_start_r;
    byte_count_nxt  = byte_count_r;
    r0  = '0;
    r1  = '0;
    cnt = 2'd0;
    // The token closed by the current word comes first in most arms.
    r0.event_type = EV_COMPLETE;
    r0.offset     = start_off;
    if (end_of_text) begin
      r1.event_type = EV_COMPLETE;
      r1.token_type = TK_END;
      r1.offset     = pos_off;
      unique case (mode_r)
        MODE_ERROR: cnt = 2'd0;
        MODE_STRING: begin
          cnt = 2'd1;
          r0.event_type = EV_ERROR;
          r0.fault_code = FAULT_UNTERM;
        end
        MODE_IDENT: begin
          cnt = 2'd2;
          r0.token_type = TK_IDENT;
        end
        MODE_NUMBER: begin
          cnt = 2'd2;
          r0.token_type = TK_NUMBER;
        end
        MODE_QUOTE: begin
          cnt = 2'd2;
          r0.token_type = TK_STRING;
        end
        default: begin
          cnt = 2'd1;
          r0  = r1;
        end
      endcase
      mode_nxt        = MODE_IDLE;
      byte_count_nxt  = '0;
      token_start_nxt = '0;
    end else begin
      r1 = bb_res;
      unique case (mode_r)
        MODE_ERROR: cnt = 2'd0;
        MODE_STRING: begin
          if (char_in == CH_QUOTE) begin
            mode_nxt = MODE_QUOTE;
          end else begin
            cnt = 2'd1;
            r0.event_type   = EV_CONTENT;
            r0.token_type   = TK_STRING;
            r0.payload_byte = char_in;
          end
        end
        MODE_QUOTE: begin
          r0.token_type = TK_STRING;
          if (char_in == CH_QUOTE) begin
            mode_nxt = MODE_STRING;
            cnt      = 2'd1;
            r0.event_type   = EV_CONTENT;
            r0.payload_byte = char_in;
          end else begin
            cnt      = 2'd1 + {1'b0, bb_emit};
            mode_nxt = bb_mode;
            if (bb_start) token_start_nxt = byte_count_r;
          end
        end
        MODE_IDENT: begin
          r0.token_type = TK_IDENT;
          if (is_alpha(char_in) || is_digit(char_in) || char_in == CH_UNDERSCORE) begin
            cnt = 2'd1;
            r0.event_type   = EV_CONTENT;
            r0.payload_byte = char_in;
          end else begin
            cnt      = 2'd1 + {1'b0, bb_emit};
            mode_nxt = bb_mode;
            if (bb_start) token_start_nxt = byte_count_r;
          end
        end
        MODE_NUMBER: begin
          r0.token_type = TK_NUMBER;
          if (is_digit(char_in)) begin
            cnt = 2'd1;
            r0.event_type   = EV_CONTENT;
            r0.payload_byte = char_in;
          end else begin
            cnt      = 2'd1 + {1'b0, bb_emit};
            mode_nxt = bb_mode;
            if (bb_start) token_start_nxt = byte_count_r;
          end
        end
        default: begin
          cnt      = {1'b0, bb_emit};
          r0       = bb_res;
          mode_nxt = bb_mode;
          if (bb_start) token_start_nxt = byte_count_r;
        end
      endcase
      if (byte_count_r != CNT_W'(MAX_TEXT_BYTES)) begin
        byte_count_nxt = byte_count_r + 1'b1;
      end
    end
    r0.final_in_run = (cnt == 2'd1);
    r1.final_in_run = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_IDLE;
      byte_count_r  <= '0;
      token_start_r <= '0;
    end else if (fire) begin
      mode_r        <= mode_nxt;
      byte_count_r  <= byte_count_nxt;
      token_start_r <= token_start_nxt;
    end
  end

  assign lex.cnt    = cnt;
  assign lex.first  = r0;
  assign lex.second = r1;

endmodule

/* rtl/sqllex_outbuf.sv */
module sqllex_outbuf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sqllex_pkg::lex_out_t lex,
  output logic                 can_take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sqllex_pkg::result_t  out_res
);
  import sqllex_pkg::*;

  logic    head_vld_r, head_vld_nxt;
  logic    spare_vld_r, spare_vld_nxt;
  result_t head_r, head_nxt;
  result_t spare_r, spare_nxt;
  logic    pop;

  assign pop      = head_vld_r && out_ready;
  // The spare slot holds the second result of a word; nothing new enters until it drains.
  assign can_take = !spare_vld_r && (!head_vld_r || out_ready);

  always_comb begin
    head_vld_nxt  = head_vld_r;
    spare_vld_nxt = spare_vld_r;
    head_nxt      = head_r;
    spare_nxt     = spare_r;
    if (pop) begin
      head_vld_nxt  = spare_vld_r;
      head_nxt      = spare_r;
      spare_vld_nxt = 1'b0;
    end
    if (push && lex.cnt != 2'd0) begin
      head_vld_nxt  = 1'b1;
      head_nxt      = lex.first;
      spare_vld_nxt = (lex.cnt == 2'd2);
      spare_nxt     = lex.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_vld_r  <= 1'b0;
      spare_vld_r <= 1'b0;
    end else begin
      head_vld_r  <= head_vld_nxt;
      spare_vld_r <= spare_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r  <= head_nxt;
    spare_r <= spare_nxt;
  end

  assign out_valid = head_vld_r;
  assign out_res   = head_r;

endmodule

/* rtl/sql_statement_lexer_core.sv */
// Channel  Dir  Width          Contents
// in_      in   tdata 8, tlast  text byte; tlast marks end of text
// out_     out  tdata 32, tuser 2, tlast  one lexer event; tlast on the last of a word
//
// Each accepted word is registered at the input, and its results are registered in the output buffer before out_.
// One word is taken per cycle while out_tready is high; a word that yields two results (a token
// closed by a byte that itself yields a result, or end of text after a pending token) holds the
// input while the spare output slot drains.
// rst_n is synchronous and returns the lexer to idle with offset zero.
// out_tready low stalls the output buffer and, through it, the input register.
`include "sql_statement_lexer_core_defines.svh"

module sql_statement_lexer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,   // end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [2:0] token_type, [15:3] offset, [23:16] payload_byte,
                                  // [24] fault_code, [31:25] zero
  output logic [1:0]  out_tuser,  // [1:0] event_type
  output logic        out_tlast   // final_in_run
);
  import sqllex_pkg::*;

  logic       in_vld_r;
  logic [7:0] in_char_r;
  logic       in_eot_r;
  logic       fire;
  logic       can_take;
  lex_out_t   lex;
  result_t    res;

  assign fire      = in_vld_r && can_take;
  assign in_tready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_char_r <= in_tdata;
      in_eot_r  <= in_tlast;
    end
  end

  sqllex_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .char_in     (in_char_r),
    .end_of_text (in_eot_r),
    .lex         (lex)
  );

  sqllex_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .lex       (lex),
    .can_take  (can_take),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {7'b0, res.fault_code, res.payload_byte, res.offset, res.token_type};
  assign out_tuser = res.event_type;
  assign out_tlast = res.final_in_run;

  `SLC_ASSERT_NEXT(a_pair_blocks_next, fire && lex.cnt == 2'd2, !fire, "second result did not block the next word")
  `SLC_ASSERT_NEXT(a_result_shown, fire && lex.cnt != 2'd0, out_tvalid, "result lost after a lexing step")
  `SLC_ASSERT_IMPLIES(a_open_pair_holds, out_tvalid && !out_tlast, !can_take, "first of a pair shown with spare slot empty")

endmodule
